// ===== rtl/guarded_heap_tag_checker_unit_defines.svh =====
// Assertion macros for the guarded heap tag checker.
`ifndef GUARDED_HEAP_TAG_CHECKER_UNIT_DEFINES_SVH
`define GUARDED_HEAP_TAG_CHECKER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GHT_ASSERT_IMPL(label, clk, rst_n, antecedent, consequent) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (antecedent) |-> (consequent)) \
    else $error("assertion failed");
`define GHT_ASSERT_NEXT(label, clk, rst_n, antecedent, consequent) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (antecedent) |=> (consequent)) \
    else $error("assertion failed");
`else
`define GHT_ASSERT_IMPL(label, clk, rst_n, antecedent, consequent)
`define GHT_ASSERT_NEXT(label, clk, rst_n, antecedent, consequent)
`endif
`endif

// ===== rtl/ghtc_pkg.sv =====
`timescale 1ns / 1ps
package ghtc_pkg;
  localparam int HEAP_BYTES = 65536;
  localparam int GUARD_BYTES = 8;
  localparam int AW = $clog2(HEAP_BYTES);
  localparam int CW = AW + 1;
  localparam int TW = 3;
  localparam logic [TW-1:0] TAG_UNINIT = 3'b001;
  localparam logic [TW-1:0] TAG_GUARD = 3'b010;
  localparam logic [TW-1:0] TAG_FREED = 3'b100;
  localparam logic [TW-1:0] TAG_CLEAR = 3'b000;
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_FREE = 2'd3;
  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_ZERO = 4'd1;
  localparam logic [3:0] ST_LIMIT = 4'd2;
  localparam logic [3:0] ST_NULL = 4'd3;
  localparam logic [3:0] ST_BELOW = 4'd4;
  localparam logic [3:0] ST_BEYOND = 4'd5;
  localparam logic [3:0] ST_GUARD = 4'd6;
  localparam logic [3:0] ST_UNINIT = 4'd7;
  localparam logic [3:0] ST_FREED = 4'd8;
  localparam logic [3:0] ST_NOTSTART = 4'd9;
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;
endpackage

// ===== rtl/ghtc_ram.sv =====
`timescale 1ns / 1ps
module ghtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/guarded_heap_tag_checker_unit.sv =====
`timescale 1ns / 1ps
`include "guarded_heap_tag_checker_unit_defines.svh"
// Flow: range and size errors go from the check straight to the result beat;
// allocation writes length + 16 tags (guards and body); read/write checks walk the bytes;
// free checks the first tag, reads the neighbor below it, then marks bytes freed.
// Throughput: one command at a time, one tag entry per cycle through the single tag RAM;
// the next command is taken in the cycle after the result beat.
// Reset: sync active low; clears used bytes, base and control; limit 65536; tag RAM not cleared.
module guarded_heap_tag_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_addr,
  input  logic [16:0] in_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [31:0] out_result_addr,
  output logic [31:0] out_fault_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ghtc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_FPREV = 3'd4;
  localparam logic [2:0] S_FREE = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] base_r;
  logic [16:0] limit_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [1:0]  cmd_r;
  logic [31:0] addr_r;
  logic [16:0] len_r;
  logic [CW-1:0] pos_r, pos_nxt, end_r, end_nxt, off_r, off_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [3:0]  st_r, st_nxt;
  logic [31:0] res_r, res_nxt, flt_r, flt_nxt;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [TW-1:0] wdata, rdata;
  logic [32:0] off_full;
  logic [CW:0] span;
  logic [CW+1:0] asum;

  ghtc_ram #(.WIDTH(TW), .DEPTH(HEAP_BYTES)) u_tags (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_result_addr = res_r;
  assign out_fault_addr = flt_r;

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    pos_nxt = pos_r;
    end_nxt = end_r;
    off_nxt = off_r;
    rd_pend_nxt = 1'b0;
    st_nxt = st_r;
    res_nxt = res_r;
    flt_nxt = flt_r;
    we = 1'b0;
    waddr = pos_r[AW-1:0];
    wdata = TAG_CLEAR;
    raddr = pos_r[AW-1:0];
    off_full = {1'b0, addr_r} - {1'b0, base_r};
    span = {1'b0, used_r} + (CW+1)'(len_r) + (CW+1)'(2 * GUARD_BYTES);
    asum = {2'b0, off_full[CW-1:0]} + (CW+2)'(len_r);
    case (state_r)
      S_CHECK: begin
        state_nxt = S_OUT;
        st_nxt = ST_OK;
        res_nxt = '0;
        flt_nxt = '0;
        if (cmd_r == CMD_ALLOC) begin
          if (len_r == '0) begin
            st_nxt = ST_ZERO;
          end else if (({1'b0, used_r} + (CW+1)'(len_r)) > (CW+1)'(limit_r) ||
                       span > (CW+1)'(HEAP_BYTES)) begin
            st_nxt = ST_LIMIT;
          end else begin
            state_nxt = S_ALLOC;
            pos_nxt = used_r;
            end_nxt = CW'(span);
            off_nxt = used_r + CW'(GUARD_BYTES);
          end
        end else if (addr_r == '0) begin
          st_nxt = ST_NULL;
          flt_nxt = addr_r;
        end else if (cmd_r != CMD_FREE && len_r == '0) begin
          st_nxt = ST_ZERO;
        end else if (off_full[32]) begin
          st_nxt = ST_BELOW;
          flt_nxt = addr_r;
        end else if (off_full[31:0] >= 32'(used_r) ||
                     (cmd_r != CMD_FREE && asum > (CW+2)'(used_r))) begin
          st_nxt = ST_BEYOND;
          flt_nxt = addr_r;
        end else begin
          pos_nxt = off_full[CW-1:0];
          off_nxt = off_full[CW-1:0];
          end_nxt = CW'(asum);
          rd_pend_nxt = 1'b1;
          raddr = off_full[AW-1:0];
          state_nxt = (cmd_r == CMD_FREE) ? S_FPREV : S_WALK;
        end
      end
      S_ALLOC: begin
        we = 1'b1;
        wdata = (pos_r < off_r || pos_r >= end_r - CW'(GUARD_BYTES)) ? TAG_GUARD : TAG_UNINIT;
        pos_nxt = pos_r + 1'b1;
        if (pos_nxt == end_r) begin
          used_nxt = end_r;
          res_nxt = base_r + 32'(off_r);
          state_nxt = S_OUT;
        end
      end
      S_WALK: begin
        if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else if (rdata[1]) begin
          st_nxt = ST_GUARD;
          flt_nxt = base_r + 32'(pos_r);
          state_nxt = S_OUT;
        end else if (cmd_r == CMD_READ && rdata[0]) begin
          st_nxt = ST_UNINIT;
          flt_nxt = base_r + 32'(pos_r);
          state_nxt = S_OUT;
        end else if (rdata[2]) begin
          st_nxt = ST_FREED;
          flt_nxt = base_r + 32'(pos_r);
          state_nxt = S_OUT;
        end else begin
          we = (cmd_r == CMD_WRITE);
          pos_nxt = pos_r + 1'b1;
          if (pos_nxt == end_r) begin
            res_nxt = 32'(off_r);
            state_nxt = S_OUT;
          end else begin
            rd_pend_nxt = 1'b1;
            raddr = pos_nxt[AW-1:0];
          end
        end
      end
      S_FPREV: begin
        if (rdata[2]) begin
          st_nxt = ST_FREED;
          flt_nxt = base_r + 32'(pos_r);
          state_nxt = S_OUT;
        end else if (rdata[1]) begin
          st_nxt = ST_GUARD;
          flt_nxt = base_r + 32'(pos_r);
          state_nxt = S_OUT;
        end else if (pos_r == '0) begin
          st_nxt = ST_NOTSTART;
          flt_nxt = base_r;
          state_nxt = S_OUT;
        end else begin
          raddr = AW'(pos_r - 1'b1);
          state_nxt = S_FREE;
          rd_pend_nxt = 1'b0;
        end
      end
      S_FREE: begin
        if (!rd_pend_r) begin
          if (!rdata[1]) begin
            st_nxt = ST_NOTSTART;
            flt_nxt = base_r + 32'(pos_r) - 32'd1;
            state_nxt = S_OUT;
          end else begin
            rd_pend_nxt = 1'b1;
          end
        end else if (pos_r >= used_r || rdata[1]) begin
          res_nxt = 32'(pos_r);
          state_nxt = S_OUT;
        end else begin
          we = 1'b1;
          wdata = TAG_FREED;
          pos_nxt = pos_r + 1'b1;
          rd_pend_nxt = 1'b1;
          raddr = pos_nxt[AW-1:0];
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      base_r <= '0;
      limit_r <= 17'd65536;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (state_r == S_IDLE && in_valid) begin
        state_r <= S_CHECK;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BASE) begin
          base_r <= cfg_data;
        end else begin
          limit_r <= cfg_data[16:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    end_r <= end_nxt;
    off_r <= off_nxt;
    st_r <= st_nxt;
    res_r <= res_nxt;
    flt_r <= flt_nxt;
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_cmd;
      addr_r <= in_addr;
      len_r <= in_length;
    end
  end

  `GHT_ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1, used_r <= CW'(HEAP_BYTES))
  `GHT_ASSERT_NEXT(a_accept_check, clk, rst_n, in_valid && !in_stall, state_r == S_CHECK)
  `GHT_ASSERT_IMPL(a_ok_no_fault, clk, rst_n, out_valid && out_status == ST_OK, out_fault_addr == '0)
endmodule

// ===== dv/guarded_heap_tag_checker_unit_tb.sv =====
`timescale 1ns / 1ps
module guarded_heap_tag_checker_unit_tb;
  import ghtc_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [16:0] length;
  } heap_cmd_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] result_addr;
    logic [31:0] fault_addr;
  } heap_resp_t;

  typedef struct {
    heap_cmd_t  req;
    logic       typed;
    heap_resp_t resp;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [31:0] in_addr;
  logic [16:0] in_length;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_status;
  logic [31:0] out_result_addr;
  logic [31:0] out_fault_addr;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;

  guarded_heap_tag_checker_unit dut (.*);

  logic [31:0] model_base;
  logic [16:0] model_limit;
  int unsigned model_used;
  logic [2:0]  model_tags [HEAP_BYTES];
  heap_resp_t  pending_resp [$];
  int unsigned errors;
  int unsigned accepted;
  int unsigned checked;
  int unsigned idle_cycles;
  int unsigned status_seen [16];
  logic        hold_receiver;
  logic [31:0] live_chunks [$];
  dir_row_t    dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic heap_resp_t mk(logic [3:0] st, logic [31:0] ra, logic [31:0] fa);
    heap_resp_t r;
    r.status = st;
    r.result_addr = ra;
    r.fault_addr = fa;
    return r;
  endfunction

  function automatic heap_resp_t predict_heap(heap_cmd_t c);
    longint unsigned addr;
    longint unsigned len;
    longint unsigned off;
    longint unsigned i;
    logic            wr;
    addr = c.addr;
    len = c.length;
    if (c.cmd == CMD_ALLOC) begin
      if (len == 0) return mk(ST_ZERO, 0, 0);
      if (model_used + len > model_limit || model_used + len + 2 * GUARD_BYTES > HEAP_BYTES)
        return mk(ST_LIMIT, 0, 0);
      off = model_used;
      for (i = 0; i < len + 2 * GUARD_BYTES; i++) begin
        model_tags[off + i] = (i < GUARD_BYTES || i >= GUARD_BYTES + len) ? TAG_GUARD : TAG_UNINIT;
      end
      model_used = 32'(off + len + 2 * GUARD_BYTES);
      return mk(ST_OK, 32'(model_base + off + GUARD_BYTES), 0);
    end
    if (addr == 0) return mk(ST_NULL, 0, 0);
    if (c.cmd != CMD_FREE && len == 0) return mk(ST_ZERO, 0, 0);
    if (addr < model_base) return mk(ST_BELOW, 0, c.addr);
    off = addr - model_base;
    if (c.cmd != CMD_FREE) begin
      wr = (c.cmd == CMD_WRITE);
      if (off >= model_used || off + len > model_used) return mk(ST_BEYOND, 0, c.addr);
      for (i = off; i < off + len; i++) begin
        if (model_tags[i] & TAG_GUARD) return mk(ST_GUARD, 0, 32'(model_base + i));
        if (!wr && (model_tags[i] & TAG_UNINIT)) return mk(ST_UNINIT, 0, 32'(model_base + i));
        if (model_tags[i] & TAG_FREED) return mk(ST_FREED, 0, 32'(model_base + i));
        if (wr) model_tags[i] = TAG_CLEAR;
      end
      return mk(ST_OK, 32'(off), 0);
    end
    if (off >= model_used) return mk(ST_BEYOND, 0, c.addr);
    if (model_tags[off] & TAG_FREED) return mk(ST_FREED, 0, 32'(model_base + off));
    if (model_tags[off] & TAG_GUARD) return mk(ST_GUARD, 0, 32'(model_base + off));
    if (off == 0) return mk(ST_NOTSTART, 0, model_base);
    if (!(model_tags[off - 1] & TAG_GUARD)) return mk(ST_NOTSTART, 0, 32'(model_base + off - 1));
    for (i = off; i < model_used && !(model_tags[i] & TAG_GUARD); i++)
      model_tags[i] = TAG_FREED;
    return mk(ST_OK, 32'(i), 0);
  endfunction

  // The receiver stalls on a rolling pattern, with stall-free stretches and one long hold-off.
  initial begin
    int unsigned phase;
    out_stall = 1'b1;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_receiver) out_stall <= 1'b1;
      else if ((phase / 300) % 3 == 0) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 35);
    end
  end

  always @(posedge clk) begin
    heap_resp_t exp_resp;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_resp.size() == 0) begin
          $error("result with nothing expected: status %0d", out_status);
          errors++;
        end else begin
          exp_resp = pending_resp.pop_front();
          checked++;
          status_seen[out_status]++;
          if (out_status !== exp_resp.status) begin
            $error("status expected %0d actual %0d", exp_resp.status, out_status);
            errors++;
          end
          if (out_result_addr !== exp_resp.result_addr) begin
            $error("result_addr expected %h actual %h", exp_resp.result_addr, out_result_addr);
            errors++;
          end
          if (out_fault_addr !== exp_resp.fault_addr) begin
            $error("fault_addr expected %h actual %h", exp_resp.fault_addr, out_fault_addr);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_row(heap_cmd_t req, logic typed, heap_resp_t resp);
    dir_row_t r;
    r.req = req;
    r.typed = typed;
    r.resp = resp;
    dir_rows = {dir_rows, r};
  endtask

  task automatic send_cmd(heap_cmd_t c);
    heap_resp_t r;
    in_valid <= 1'b1;
    in_cmd <= c.cmd;
    in_addr <= c.addr;
    in_length <= c.length;
    do @(posedge clk); while (in_stall);
    r = predict_heap(c);
    pending_resp = {pending_resp, r};
    accepted++;
    if (c.cmd == CMD_ALLOC && r.status == ST_OK) live_chunks = {live_chunks, r.result_addr};
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    drop_valid();
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BASE) model_base = data;
    else model_limit = data[16:0];
    @(posedge clk);
  endtask

  function automatic heap_cmd_t mkcmd(logic [1:0] c, logic [31:0] a, logic [16:0] l);
    heap_cmd_t r;
    r.cmd = c;
    r.addr = a;
    r.length = l;
    return r;
  endfunction

  function automatic heap_cmd_t random_cmd();
    heap_cmd_t  c;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    c.addr = $urandom();
    c.length = 17'($urandom());
    span = (model_used == 0) ? 1 : model_used;
    if (pick < 20 || model_used == 0) begin
      c.cmd = CMD_ALLOC;
      c.length = ($urandom_range(0, 49) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 40));
    end else if (pick < 85) begin
      c.cmd = 2'($urandom_range(1, 3));
      if (live_chunks.size() != 0 && $urandom_range(0, 3) != 0)
        c.addr = live_chunks[$urandom_range(0, live_chunks.size() - 1)]
                 + $urandom_range(0, 2) - 1;
      else c.addr = model_base + $urandom_range(0, span);
      c.length = 17'($urandom_range(0, 24));
    end else if (pick < 90) begin
      c.cmd = 2'($urandom_range(1, 3));
      c.addr = '0;
    end else begin
      c.cmd = 2'($urandom_range(1, 3));
    end
    return c;
  endfunction

  initial begin
    dir_row_t    row;
    heap_resp_t  got;
    int unsigned burst;
    int unsigned phase_no;
    int unsigned sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_ALLOC;
    in_addr = '0;
    in_length = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BASE;
    cfg_data = '0;
    hold_receiver = 1'b0;
    errors = 0;
    accepted = 0;
    checked = 0;
    model_base = '0;
    model_limit = 17'd65536;
    model_used = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(mkcmd(CMD_READ, 32'h0, 17'd4), 1'b1, mk(ST_NULL, 0, 0));
    add_row(mkcmd(CMD_READ, 32'h10, 17'd0), 1'b1, mk(ST_ZERO, 0, 0));
    add_row(mkcmd(CMD_READ, 32'h10, 17'd1), 1'b1, mk(ST_BEYOND, 0, 32'h10));
    add_row(mkcmd(CMD_FREE, 32'hFFFFFFFF, 17'h1FFFF), 1'b1, mk(ST_BEYOND, 0, 32'hFFFFFFFF));
    add_row(mkcmd(CMD_ALLOC, 32'hFFFFFFFF, 17'd0), 1'b1, mk(ST_ZERO, 0, 0));
    add_row(mkcmd(CMD_ALLOC, 32'h0, 17'h1FFFF), 1'b1, mk(ST_LIMIT, 0, 0));
    add_row(mkcmd(CMD_ALLOC, 32'h0, 17'd65536), 1'b1, mk(ST_LIMIT, 0, 0));
    add_row(mkcmd(CMD_ALLOC, 32'h0, 17'd16), 1'b1, mk(ST_OK, 32'd8, 0));
    add_row(mkcmd(CMD_READ, 32'd8, 17'd1), 1'b1, mk(ST_UNINIT, 0, 32'd8));
    add_row(mkcmd(CMD_WRITE, 32'd8, 17'd4), 1'b1, mk(ST_OK, 32'd8, 0));
    add_row(mkcmd(CMD_READ, 32'd8, 17'd4), 1'b1, mk(ST_OK, 32'd8, 0));
    add_row(mkcmd(CMD_READ, 32'd8, 17'd5), 1'b1, mk(ST_UNINIT, 0, 32'd12));
    add_row(mkcmd(CMD_WRITE, 32'd20, 17'd8), 1'b1, mk(ST_GUARD, 0, 32'd24));
    add_row(mkcmd(CMD_WRITE, 32'd2, 17'd2), 1'b1, mk(ST_GUARD, 0, 32'd2));
    add_row(mkcmd(CMD_FREE, 32'd9, 17'd0), 1'b1, mk(ST_NOTSTART, 0, 32'd8));
    add_row(mkcmd(CMD_FREE, 32'd4, 17'd0), 1'b1, mk(ST_GUARD, 0, 32'd4));
    add_row(mkcmd(CMD_FREE, 32'd8, 17'd0), 1'b1, mk(ST_OK, 32'd24, 0));
    add_row(mkcmd(CMD_FREE, 32'd8, 17'd0), 1'b1, mk(ST_FREED, 0, 32'd8));
    add_row(mkcmd(CMD_WRITE, 32'd10, 17'd2), 1'b1, mk(ST_FREED, 0, 32'd10));
    add_row(mkcmd(CMD_READ, 32'd30, 17'd3), 1'b1, mk(ST_BEYOND, 0, 32'd30));
    add_row(mkcmd(CMD_ALLOC, 32'h0, 17'd1), 1'b0, mk(0, 0, 0));
    add_row(mkcmd(CMD_WRITE, 32'd40, 17'd1), 1'b0, mk(0, 0, 0));
    add_row(mkcmd(CMD_READ, 32'd40, 17'd1), 1'b0, mk(0, 0, 0));
    add_row(mkcmd(CMD_FREE, 32'd40, 17'h1FFFF), 1'b0, mk(0, 0, 0));

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      send_cmd(row.req);
      if (row.typed) begin
        got = pending_resp[pending_resp.size() - 1];
        if (got !== row.resp) begin
          $error("directed row %0d: expected %h computed %h", k, row.resp, got);
          errors++;
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        drop_valid();
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    drain();

    // Base above zero, then a tight limit, then the base at the top with the address wrapping.
    write_cfg(CFG_BASE, 32'h0000_1000);
    write_cfg(CFG_LIMIT, 32'd65536);
    send_cmd(mkcmd(CMD_READ, 32'h0000_0FFF, 17'd1));
    drain();

    sent = 0;
    for (phase_no = 0; phase_no < 4; phase_no++) begin
      if (phase_no == 1) write_cfg(CFG_LIMIT, 32'd300);
      if (phase_no == 2) begin
        write_cfg(CFG_BASE, 32'hFFFF_FF00);
        write_cfg(CFG_LIMIT, 32'd0);
        send_cmd(mkcmd(CMD_ALLOC, 32'h0, 17'd1));
        drain();
        write_cfg(CFG_LIMIT, 32'd2000);
      end
      if (phase_no == 3) write_cfg(CFG_LIMIT, 32'd65536);
      model_used = model_used;
      while (sent < (phase_no + 1) * RANDOM_ITEMS / 4) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          send_cmd(random_cmd());
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          drop_valid();
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        if (sent % 200 < 12 && $urandom_range(0, 1) == 0) drain();
      end
      hold_receiver = 1'b0;
      drain();
      live_chunks.delete();
    end

    // Long receiver hold-off while the sender keeps offering commands.
    fork
      begin
        hold_receiver = 1'b1;
        repeat (400) @(posedge clk);
        hold_receiver = 1'b0;
      end
      begin
        repeat (8) send_cmd(random_cmd());
      end
    join
    drain();

    $display("Commands accepted: %0d, results checked: %0d.", accepted, checked);
    $display("Status counts ok %0d, guard %0d, uninit %0d, freed %0d, not start %0d.",
             status_seen[ST_OK], status_seen[ST_GUARD], status_seen[ST_UNINIT],
             status_seen[ST_FREED], status_seen[ST_NOTSTART]);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
